@@ hw/rtl/dsf_pkg.sv @@
package dsf_pkg;

    // Default internal word width, signed fixed point.
    localparam int DSF_DATA_WIDTH = 32;
    localparam int FRAC_BITS      = 16;
    localparam int HOOKE_SCALE    = 984;

    // Stream layout
    localparam int FIELD_W    = 32;
    localparam int IN_DATA_W  = 9 * FIELD_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 3 * FIELD_W;
    localparam int OUT_USER_W = 3;

    localparam int USR_LOCK_A  = 0;
    localparam int USR_LOCK_B  = 1;
    localparam int USR_APPLY_A = 0;
    localparam int USR_APPLY_B = 1;
    localparam int USR_DEG     = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPRING  = 2'd0,
        CFG_DAMPING = 2'd1,
        CFG_REST    = 2'd2
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] SPRING_RESET  = 32'd58982;
    localparam logic [CFG_DATA_W-1:0] DAMPING_RESET = 32'd98304;
    localparam logic [CFG_DATA_W-1:0] REST_RESET    = 32'd65536;

endpackage

@@ hw/rtl/damped_spring_force.sv @@
// Channel  | Direction | tdata (low bit first)                     | tuser (low bit first)
// s_axis   | in        | pos_a_x/y/z, pos_b_x/y/z, rel_vel_x/y/z   | lock_a, lock_b
// m_axis   | out       | force_x, force_y, force_z                 | apply_to_a, apply_to_b,
//          |           |                                           | degenerate
// cfg      | in        | cfg_wen, cfg_index, cfg_data              | -
//
// One transaction enters per cycle while the pipeline is not held. The pipeline depth is set
// by the bit-per-stage square root (DATA_WIDTH stages) and the restoring dividers
// (DATA_WIDTH+16 stages).
// rst_n clears the valid chain and loads the register reset values.
// The whole pipeline advances together: it holds while a result sits on m_axis
// unaccepted, and s_axis_tready is low only in those cycles.
module damped_spring_force
    import dsf_pkg::*;
#(
    parameter int DATA_WIDTH = DSF_DATA_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, rel_vel_x, rel_vel_y, rel_vel_z
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // lock_a, lock_b
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // force_x, force_y, force_z
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // apply_to_a, apply_to_b, degenerate
    output logic [OUT_USER_W-1:0]  m_axis_tuser,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int BW  = 2 * W + 24;       // wide enough for every unsaturated value
    localparam int NW  = W + FRAC_BITS;    // dividend width, one quotient bit per stage
    localparam int LAT = 2 * W + 35;

    typedef logic signed [W-1:0] fx_t;

    localparam fx_t S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam fx_t S_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] s;
        logic              lka;
        logic              lkb;
    } pre_t;

    typedef struct packed {
        logic [2:0][W-1:0] s;
        logic [W-1:0]      n;
        logic              lka;
        logic              lkb;
    } sq_side_t;

    typedef struct packed {
        logic [2:0][W-1:0] s;
        logic [W-1:0]      n;
        logic [W-1:0]      len;
        logic              lka;
        logic              lkb;
        logic              deg;
    } hk_t;

    typedef struct packed {
        logic [W-1:0] hooke;
        logic [2:0]   sneg;
        logic         nneg;
        logic         lka;
        logic         lkb;
        logic         deg;
    } dv_side_t;

    // Saturate a two's complement wide value to W bits.
    function automatic fx_t sat_s(input logic signed [BW-1:0] v);
        logic [BW-W:0] top;
        top = v[BW-1:W-1];
        if (&top || ~|top)
            return v[W-1:0];
        else if (v[BW-1])
            return S_MIN;
        else
            return S_MAX;
    endfunction

    // Apply a sign to a magnitude and saturate to W bits.
    function automatic fx_t sat_m(input logic neg, input logic [BW-1:0] mag);
        logic [W-1:0] m;
        m = mag[W-1:0];
        if (|mag[BW-1:W-1])
            return neg ? S_MIN : S_MAX;
        else
            return neg ? (~m + 1'b1) : m;
    endfunction

    function automatic logic [W-1:0] mag_of(input fx_t v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [FIELD_W-1:0] sat32(input fx_t v);
        logic signed [BW-1:0] x;
        logic [BW-32:0]       top;
        x   = BW'(v);
        top = x[BW-1:31];
        if (&top || ~|top)
            return x[31:0];
        else
            return x[BW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: every stage advances together.
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // ------------------------------------------------------------------
    // Configuration registers and their saturated working copies.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] spring_reg;
    logic [CFG_DATA_W-1:0] damping_reg;
    logic [CFG_DATA_W-1:0] rest_reg;
    fx_t                   ksat_reg;
    fx_t                   dsat_reg;
    fx_t                   rsat_reg;
    logic [41:0]           kscaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_reg  <= SPRING_RESET;
            damping_reg <= DAMPING_RESET;
            rest_reg    <= REST_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SPRING:  spring_reg  <= cfg_data;
                CFG_DAMPING: damping_reg <= cfg_data;
                CFG_REST:    rest_reg    <= cfg_data;
                default:     ;  // unknown index: drop the write
            endcase
        end
    end

    assign kscaled = 42'(spring_reg) * 42'(HOOKE_SCALE);

    // Registers are quasi-static, so refresh the derived copies every cycle.
    always_ff @(posedge clk)
    begin
        ksat_reg <= sat_s(BW'(kscaled));
        dsat_reg <= sat_s(BW'(damping_reg));
        rsat_reg <= sat_s(BW'(rest_reg));
    end

    // ------------------------------------------------------------------
    // Stage 0: capture and clamp inputs to the working width.
    // ------------------------------------------------------------------
    fx_t  pa_reg [3];
    fx_t  pb_reg [3];
    fx_t  v0_reg [3];
    logic lka0_reg;
    logic lkb0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= sat_s(BW'($signed(s_axis_tdata[FIELD_W*i +: FIELD_W])));
                pb_reg[i] <= sat_s(BW'($signed(s_axis_tdata[FIELD_W*(i+3) +: FIELD_W])));
                v0_reg[i] <= sat_s(BW'($signed(s_axis_tdata[FIELD_W*(i+6) +: FIELD_W])));
            end
            lka0_reg <= s_axis_tuser[USR_LOCK_A];
            lkb0_reg <= s_axis_tuser[USR_LOCK_B];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: separation vector. Carry it and the locks to the square root.
    // ------------------------------------------------------------------
    pre_t pre_next;
    pre_t pre_reg [8];
    fx_t  v1_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pre_next.s[i] = sat_s(BW'(pa_reg[i]) - BW'(pb_reg[i]));
        pre_next.lka = lka0_reg;
        pre_next.lkb = lkb0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg[0] <= pre_next;
            for (int k = 1; k < 8; k++)
                pre_reg[k] <= pre_reg[k-1];
            v1_reg <= v0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-3: squares of the separation and velocity*separation terms.
    // ------------------------------------------------------------------
    logic [2*W-1:0] sq_p [3];
    logic [2*W-1:0] mv_p [3];
    logic [2:0]     mneg_reg [2];

    for (genvar i = 0; i < 3; i++)
    begin : g_mul_in
        dsf_mul #(.W(W)) u_sq (
            .clk (clk),
            .en  (en),
            .a   (mag_of(pre_reg[0].s[i])),
            .b   (mag_of(pre_reg[0].s[i])),
            .p   (sq_p[i])
        );
        dsf_mul #(.W(W)) u_mv (
            .clk (clk),
            .en  (en),
            .a   (mag_of(v1_reg[i])),
            .b   (mag_of(pre_reg[0].s[i])),
            .p   (mv_p[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                mneg_reg[0][i] <= v1_reg[i][W-1] ^ pre_reg[0].s[i][W-1];
            mneg_reg[1] <= mneg_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-8: sum of squares, dot product, times damping.
    // ------------------------------------------------------------------
    logic [2*W-1:0] s_reg [5];
    fx_t            m_reg [3];
    fx_t            dot_reg;
    logic           dneg_reg [2];
    logic [2*W-1:0] dd_p;
    fx_t            n_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= sq_p[0] + sq_p[1] + sq_p[2];
            for (int k = 1; k < 5; k++)
                s_reg[k] <= s_reg[k-1];
            for (int i = 0; i < 3; i++)
                m_reg[i] <= sat_m(mneg_reg[1][i], BW'(mv_p[i] >> FRAC_BITS));
            dot_reg     <= sat_s(BW'(m_reg[0]) + BW'(m_reg[1]) + BW'(m_reg[2]));
            dneg_reg[0] <= dot_reg[W-1];
            dneg_reg[1] <= dneg_reg[0];
            n_reg       <= sat_m(dneg_reg[1], BW'(dd_p >> FRAC_BITS));
        end
    end

    dsf_mul #(.W(W)) u_dd (
        .clk (clk),
        .en  (en),
        .a   (mag_of(dot_reg)),
        .b   (dsat_reg),
        .p   (dd_p)
    );

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, two radicand bits consumed.
    // ------------------------------------------------------------------
    logic [W:0]     sq_rem_reg  [W];
    logic [W-1:0]   sq_root_reg [W];
    logic [2*W-1:0] sq_s_reg    [W];
    sq_side_t       sq_side_reg [W];

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        logic [W:0]     rem_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] s_in;
        sq_side_t       side_in;
        logic [W+2:0]   t;
        logic [W+2:0]   trial;
        logic [W+2:0]   diff;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = s_reg[4];
            assign side_in = '{s: pre_reg[7].s, n: n_reg,
                               lka: pre_reg[7].lka, lkb: pre_reg[7].lkb};
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign s_in    = sq_s_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        assign t     = {rem_in, s_in[2*W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = t - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (t >= trial)
                begin
                    sq_rem_reg[k]  <= diff[W:0];
                    sq_root_reg[k] <= {root_in[W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= t[W:0];
                    sq_root_reg[k] <= {root_in[W-2:0], 1'b0};
                end
                sq_s_reg[k]    <= {s_in[2*W-3:0], 2'b00};
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Length, then the Hooke term (len - rest) * k.
    // ------------------------------------------------------------------
    logic [W-1:0]   root_fin;
    fx_t            len_next;
    hk_t            hk_reg [5];
    fx_t            diff_reg;
    logic           hneg_reg [2];
    logic [2*W-1:0] hk_p;
    fx_t            hooke_reg;

    assign root_fin = sq_root_reg[W-1];
    assign len_next = root_fin[W-1] ? S_MAX : root_fin;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hk_reg[0] <= '{s: sq_side_reg[W-1].s, n: sq_side_reg[W-1].n, len: len_next,
                           lka: sq_side_reg[W-1].lka, lkb: sq_side_reg[W-1].lkb,
                           deg: ~|root_fin};
            for (int k = 1; k < 5; k++)
                hk_reg[k] <= hk_reg[k-1];
            diff_reg    <= sat_s(BW'($signed(hk_reg[0].len)) - BW'(rsat_reg));
            hneg_reg[0] <= diff_reg[W-1];
            hneg_reg[1] <= hneg_reg[0];
            hooke_reg   <= sat_m(hneg_reg[1], BW'(hk_p >> FRAC_BITS));
        end
    end

    dsf_mul #(.W(W)) u_hk (
        .clk (clk),
        .en  (en),
        .a   (mag_of(diff_reg)),
        .b   (ksat_reg),
        .p   (hk_p)
    );

    // ------------------------------------------------------------------
    // Dividers by len: lanes 0-2 give the direction, lane 3 the damping.
    // Restoring division, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic [W-1:0]  dv_mag0     [4];
    dv_side_t      dv_side0;
    logic [W-1:0]  dv_rem_reg  [NW][4];
    logic [NW-1:0] dv_q_reg    [NW][4];
    logic [NW-1:0] dv_num_reg  [NW][4];
    logic [W-1:0]  dv_len_reg  [NW];
    dv_side_t      dv_side_reg [NW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dv_mag0[i] = mag_of(hk_reg[4].s[i]);
        dv_mag0[3] = mag_of(hk_reg[4].n);
        dv_side0.hooke = hooke_reg;
        for (int i = 0; i < 3; i++)
            dv_side0.sneg[i] = hk_reg[4].s[i][W-1];
        dv_side0.nneg = hk_reg[4].n[W-1];
        dv_side0.lka  = hk_reg[4].lka;
        dv_side0.lkb  = hk_reg[4].lkb;
        dv_side0.deg  = hk_reg[4].deg;
    end

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        logic [W-1:0] len_in;
        dv_side_t     side_in;

        if (j == 0)
        begin : g_first
            assign len_in  = hk_reg[4].len;
            assign side_in = dv_side0;
        end
        else
        begin : g_next
            assign len_in  = dv_len_reg[j-1];
            assign side_in = dv_side_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[j]  <= len_in;
                dv_side_reg[j] <= side_in;
            end
        end

        for (genvar d = 0; d < 4; d++)
        begin : g_lane
            logic [W-1:0]  rem_in;
            logic [NW-1:0] q_in;
            logic [NW-1:0] num_in;
            logic [W:0]    t;
            logic [W:0]    sub;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign rem_in = '0;
                assign q_in   = '0;
                assign num_in = {dv_mag0[d], {FRAC_BITS{1'b0}}};
            end
            else
            begin : g_next
                assign rem_in = dv_rem_reg[j-1][d];
                assign q_in   = dv_q_reg[j-1][d];
                assign num_in = dv_num_reg[j-1][d];
            end

            assign t   = {rem_in, num_in[NW-1]};
            assign ge  = t >= {1'b0, len_in};
            assign sub = t - {1'b0, len_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[j][d] <= ge ? sub[W-1:0] : t[W-1:0];
                    dv_q_reg[j][d]   <= {q_in[NW-2:0], ge};
                    dv_num_reg[j][d] <= {num_in[NW-2:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Direction and damping, total magnitude, then force = dir * total.
    // ------------------------------------------------------------------
    fx_t            dir_reg [3];
    fx_t            dmp_reg;
    dv_side_t       qs_reg;
    fx_t            dirt_reg [3];
    fx_t            total_reg;
    dv_side_t       ts_reg;
    logic [2:0]     fneg_reg [2];
    dv_side_t       fs_reg [2];
    logic [2*W-1:0] fo_p [3];
    fx_t            fo_fm [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                dir_reg[i] <= sat_m(dv_side_reg[NW-1].sneg[i], BW'(dv_q_reg[NW-1][i]));
            dmp_reg   <= sat_m(dv_side_reg[NW-1].nneg, BW'(dv_q_reg[NW-1][3]));
            qs_reg    <= dv_side_reg[NW-1];
            total_reg <= sat_s(-BW'(sat_s(BW'($signed(qs_reg.hooke)) + BW'(dmp_reg))));
            dirt_reg  <= dir_reg;
            ts_reg    <= qs_reg;
            for (int i = 0; i < 3; i++)
                fneg_reg[0][i] <= dirt_reg[i][W-1] ^ total_reg[W-1];
            fneg_reg[1] <= fneg_reg[0];
            fs_reg[0]   <= ts_reg;
            fs_reg[1]   <= fs_reg[0];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_mul_out
        dsf_mul #(.W(W)) u_fo (
            .clk (clk),
            .en  (en),
            .a   (mag_of(dirt_reg[i])),
            .b   (mag_of(total_reg)),
            .p   (fo_p[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            fo_fm[i] = sat_m(fneg_reg[1][i], BW'(fo_p[i] >> FRAC_BITS));
    end

    // Output register; coincident particles report a zero force.
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                out_data_reg[FIELD_W*i +: FIELD_W] <= fs_reg[1].deg ? '0 : sat32(fo_fm[i]);
            out_user_reg[USR_APPLY_A] <= ~fs_reg[1].lka;
            out_user_reg[USR_APPLY_B] <= ~fs_reg[1].lkb;
            out_user_reg[USR_DEG]     <= fs_reg[1].deg;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

endmodule

@@ hw/rtl/dsf_mul.sv @@
module dsf_mul
    import dsf_pkg::*;
#(
    parameter int W = DSF_DATA_WIDTH
)(
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int PW = 2 * W;

    logic [2*H-1:0] ll_reg;
    logic [W-1:0]   lh_reg;
    logic [W-1:0]   hl_reg;
    logic [2*L-1:0] hh_reg;
    logic [PW-1:0]  p_reg;

    // Split into half-width partial products, register them, then sum them into p_reg.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[H-1:0] * b[H-1:0];
            lh_reg <= a[H-1:0] * b[W-1:H];
            hl_reg <= a[W-1:H] * b[H-1:0];
            hh_reg <= a[W-1:H] * b[W-1:H];
            p_reg  <= PW'(ll_reg) + ((PW'(lh_reg) + PW'(hl_reg)) << H)
                      + (PW'(hh_reg) << (2 * H));
        end
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/dsf_chk.sv @@
module dsf_chk
    import dsf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // Input side stalls exactly when a result waits on the output.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("s_axis_tready does not follow the output stall");

    // Coincident particles carry a zero force.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USR_DEG] |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero force");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

endmodule

bind damped_spring_force dsf_chk u_dsf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
